// ----- hw/rtl/vict_pkg.sv -----
// vict_pkg: widths, register indexes, part codes and shared structs for the
// voxel-in-capsule test unit. Depends on nothing; used by every vict module.
`default_nettype none

package vict_pkg;

	// field widths
	localparam int COORD_BITS     = 16;
	localparam int DIAM_FRAC_BITS = 4;
	localparam int DIAM_W         = 12;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 5;
	localparam int REG_IDX_W      = ADDR_W - 2;

	// datapath widths, derived from the coordinate, fraction and diameter widths
	localparam int DIFF_W = COORD_BITS + 1;            // signed coordinate difference
	localparam int PROD_W = 2 * DIFF_W;                // signed product of two differences
	localparam int SQ_W   = 2 * COORD_BITS;            // one squared difference
	localparam int SUM_W  = SQ_W + 2;                  // sum of three squares
	localparam int DOT_W  = PROD_W + 1;                // signed dot product
	localparam int CRS_W  = PROD_W + 1;                // signed cross product component
	localparam int MAG_W  = CRS_W - 1;                 // magnitude of a cross component
	localparam int LO_W   = (MAG_W + 1) / 2;           // low half of a magnitude
	localparam int HI_W   = MAG_W - LO_W;              // high half of a magnitude
	localparam int CSQ_W  = 2 * MAG_W;                 // squared cross component
	localparam int CS_W   = CSQ_W + 2;                 // squared cross product length
	localparam int SH_K   = 2 * DIAM_FRAC_BITS + 2;    // scale of squared distances
	localparam int DSQ_W  = 2 * DIAM_W;                // squared diameter
	localparam int LL_W   = (SUM_W + 1) / 2;           // low half of the squared length
	localparam int LH_W   = SUM_W - LL_W;              // high half of the squared length
	localparam int D2L_W  = SUM_W + DSQ_W;             // squared diameter times squared length
	localparam int CMP_W  = (CS_W + SH_K > D2L_W) ? CS_W + SH_K : D2L_W;
	localparam int EP_W   = (SUM_W + SH_K > DSQ_W) ? SUM_W + SH_K : DSQ_W;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_START_X = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_START_Y = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_START_Z = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_END_X   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_END_Y   = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_END_Z   = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_DIAM    = REG_IDX_W'(6);

	localparam logic [DIAM_W-1:0] DIAM_RST = DIAM_W'(16);
	localparam logic [DSQ_W-1:0]  DSQ_RST  = DSQ_W'(256);

	// nearest part codes
	localparam logic [1:0] PART_MID   = 2'd0;
	localparam logic [1:0] PART_START = 2'd1;
	localparam logic [1:0] PART_END   = 2'd2;
	localparam logic [1:0] PART_DEGEN = 2'd3;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] start_z;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic [COORD_BITS-1:0] end_z;
		logic [DSQ_W-1:0]      dsq;
	} cfg_t;

	// geometry sums handed from the front end to the back end
	typedef struct packed {
		logic [SUM_W-1:0]            len_sq;
		logic [SUM_W-1:0]            st_sq;
		logic [SUM_W-1:0]            end_sq;
		logic [DOT_W-1:0]            dot;
		logic [2:0][MAG_W-1:0]       cmag;
	} geom_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vict_cfg.sv -----
// vict_cfg: APB register file for the segment end points and the diameter,
// plus the registered squared diameter. Depends on vict_pkg.
`default_nettype none

module vict_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [vict_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [vict_pkg::DATA_W-1:0]  pwdata,
	output logic      [vict_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output vict_pkg::cfg_t                    cfg
);

	logic [vict_pkg::COORD_BITS-1:0] start_x_q, start_y_q, start_z_q;
	logic [vict_pkg::COORD_BITS-1:0] end_x_q, end_y_q, end_z_q;
	logic [vict_pkg::DIAM_W-1:0]     diam_q;
	logic [vict_pkg::DSQ_W-1:0]      dsq_q;
	logic [vict_pkg::REG_IDX_W-1:0]  idx;
	logic                            wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[vict_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;

	// register writes; the squared diameter follows in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			end_z_q   <= '0;
			diam_q    <= vict_pkg::DIAM_RST;
			dsq_q     <= vict_pkg::DSQ_RST;
		end else begin
			dsq_q <= vict_pkg::DSQ_W'(diam_q) * vict_pkg::DSQ_W'(diam_q);
			if (wr_en) begin
				case (idx)
					vict_pkg::REG_START_X: start_x_q <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_START_Y: start_y_q <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_START_Z: start_z_q <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_END_X:   end_x_q   <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_END_Y:   end_y_q   <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_END_Z:   end_z_q   <= pwdata[vict_pkg::COORD_BITS-1:0];
					vict_pkg::REG_DIAM:    diam_q    <= pwdata[vict_pkg::DIAM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// read mux
	always_comb begin
		case (idx)
			vict_pkg::REG_START_X: prdata = vict_pkg::DATA_W'(start_x_q);
			vict_pkg::REG_START_Y: prdata = vict_pkg::DATA_W'(start_y_q);
			vict_pkg::REG_START_Z: prdata = vict_pkg::DATA_W'(start_z_q);
			vict_pkg::REG_END_X:   prdata = vict_pkg::DATA_W'(end_x_q);
			vict_pkg::REG_END_Y:   prdata = vict_pkg::DATA_W'(end_y_q);
			vict_pkg::REG_END_Z:   prdata = vict_pkg::DATA_W'(end_z_q);
			vict_pkg::REG_DIAM:    prdata = vict_pkg::DATA_W'(diam_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.start_x = start_x_q;
	assign cfg.start_y = start_y_q;
	assign cfg.start_z = start_z_q;
	assign cfg.end_x   = end_x_q;
	assign cfg.end_y   = end_y_q;
	assign cfg.end_z   = end_z_q;
	assign cfg.dsq     = dsq_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vict_front.sv -----
// vict_front: stages 1 to 3 of the pipeline: coordinate differences, products,
// and the sums of squares, dot product and cross product magnitudes.
// Depends on vict_pkg.
`default_nettype none

module vict_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_y,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_z,
	input  wire vict_pkg::cfg_t                         cfg,
	output logic                                       valid_s3,
	output vict_pkg::geom_t                            geom_s3
);

	logic [vict_pkg::COORD_BITS-1:0]    pt [3];
	logic [vict_pkg::COORD_BITS-1:0]    st [3];
	logic [vict_pkg::COORD_BITS-1:0]    en [3];
	logic signed [vict_pkg::DIFF_W-1:0] ab_d [3];
	logic signed [vict_pkg::DIFF_W-1:0] ap_d [3];
	logic signed [vict_pkg::DIFF_W-1:0] bp_d [3];

	logic                               valid_s1, valid_s2;
	logic signed [vict_pkg::DIFF_W-1:0] ab_s1 [3];
	logic signed [vict_pkg::DIFF_W-1:0] ap_s1 [3];
	logic signed [vict_pkg::DIFF_W-1:0] bp_s1 [3];

	logic signed [vict_pkg::PROD_W-1:0] ll_s2 [3];
	logic signed [vict_pkg::PROD_W-1:0] ss_s2 [3];
	logic signed [vict_pkg::PROD_W-1:0] ff_s2 [3];
	logic signed [vict_pkg::PROD_W-1:0] dp_s2 [3];
	logic signed [vict_pkg::PROD_W-1:0] cra_s2 [3];
	logic signed [vict_pkg::PROD_W-1:0] crb_s2 [3];

	vict_pkg::geom_t                    geom_d;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;
	assign st[0] = cfg.start_x;
	assign st[1] = cfg.start_y;
	assign st[2] = cfg.start_z;
	assign en[0] = cfg.end_x;
	assign en[1] = cfg.end_y;
	assign en[2] = cfg.end_z;

	// per-axis differences: segment, start-to-point, end-to-point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ab_d[i] = $signed({en[i][vict_pkg::COORD_BITS-1], en[i]})
				- $signed({st[i][vict_pkg::COORD_BITS-1], st[i]});
			ap_d[i] = $signed({pt[i][vict_pkg::COORD_BITS-1], pt[i]})
				- $signed({st[i][vict_pkg::COORD_BITS-1], st[i]});
			bp_d[i] = $signed({pt[i][vict_pkg::COORD_BITS-1], pt[i]})
				- $signed({en[i][vict_pkg::COORD_BITS-1], en[i]});
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ab_s1[i] <= ab_d[i];
			ap_s1[i] <= ap_d[i];
			bp_s1[i] <= bp_d[i];
		end
	end

	// stage 2: squares, dot terms and cross product terms
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ll_s2[i] <= ab_s1[i] * ab_s1[i];
			ss_s2[i] <= ap_s1[i] * ap_s1[i];
			ff_s2[i] <= bp_s1[i] * bp_s1[i];
			dp_s2[i] <= ap_s1[i] * ab_s1[i];
		end
		cra_s2[0] <= ap_s1[1] * ab_s1[2];
		crb_s2[0] <= ap_s1[2] * ab_s1[1];
		cra_s2[1] <= ap_s1[2] * ab_s1[0];
		crb_s2[1] <= ap_s1[0] * ab_s1[2];
		cra_s2[2] <= ap_s1[0] * ab_s1[1];
		crb_s2[2] <= ap_s1[1] * ab_s1[0];
	end

	// stage 3 inputs: sums over the axes, cross product magnitudes
	always_comb begin
		logic signed [vict_pkg::CRS_W-1:0] crs;
		geom_d.len_sq = vict_pkg::SUM_W'(ll_s2[0][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ll_s2[1][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ll_s2[2][vict_pkg::SQ_W-1:0]);
		geom_d.st_sq  = vict_pkg::SUM_W'(ss_s2[0][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ss_s2[1][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ss_s2[2][vict_pkg::SQ_W-1:0]);
		geom_d.end_sq = vict_pkg::SUM_W'(ff_s2[0][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ff_s2[1][vict_pkg::SQ_W-1:0])
			+ vict_pkg::SUM_W'(ff_s2[2][vict_pkg::SQ_W-1:0]);
		geom_d.dot    = vict_pkg::DOT_W'(dp_s2[0]) + vict_pkg::DOT_W'(dp_s2[1])
			+ vict_pkg::DOT_W'(dp_s2[2]);
		for (int i = 0; i < 3; i++) begin
			crs = vict_pkg::CRS_W'(cra_s2[i]) - vict_pkg::CRS_W'(crb_s2[i]);
			geom_d.cmag[i] = crs[vict_pkg::CRS_W-1] ? vict_pkg::MAG_W'(-crs)
				: vict_pkg::MAG_W'(crs);
		end
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		geom_s3 <= geom_d;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/vict_back.sv -----
// vict_back: stages 4 to 7: nearest part decision, endpoint test, split
// squaring of the cross product and the final cross-multiplied compare.
// Depends on vict_pkg.
`default_nettype none

module vict_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s3,
	input  wire vict_pkg::geom_t               geom_s3,
	input  wire logic [vict_pkg::DSQ_W-1:0]    dsq,
	output logic                               done,
	output logic                               inside_res,
	output logic [1:0]                         nearest_part
);

	logic [1:0]                    part_d;
	logic [vict_pkg::SUM_W-1:0]    ep_dist;
	logic [vict_pkg::EP_W-1:0]     ep_lhs;
	logic                          ep_in_d;

	logic                                  valid_s4, valid_s5, valid_s6, valid_s7;
	logic [1:0]                            part_s4, part_s5, part_s6, part_s7;
	logic                                  ep_in_s4, ep_in_s5, ep_in_s6;
	logic [2*vict_pkg::HI_W-1:0]           hh_s4 [3];
	logic [vict_pkg::HI_W+vict_pkg::LO_W-1:0] hl_s4 [3];
	logic [2*vict_pkg::LO_W-1:0]           lo2_s4 [3];
	logic [vict_pkg::LH_W+vict_pkg::DSQ_W-1:0] pa_s4;
	logic [vict_pkg::LL_W+vict_pkg::DSQ_W-1:0] pb_s4;

	logic [vict_pkg::CSQ_W-1:0]    csq_s5 [3];
	logic [vict_pkg::D2L_W-1:0]    d2l_s5, d2l_s6;
	logic [vict_pkg::CS_W-1:0]     csum_s6;
	logic [vict_pkg::CMP_W-1:0]    mid_lhs;
	logic                          inside_s7;

	// nearest part: degenerate, at or before start, at or past far end, or interior
	always_comb begin
		if (geom_s3.len_sq == '0) begin
			part_d = vict_pkg::PART_DEGEN;
		end else if (geom_s3.dot[vict_pkg::DOT_W-1] || geom_s3.dot == '0) begin
			part_d = vict_pkg::PART_START;
		end else if ($signed(geom_s3.dot) >= $signed({1'b0, geom_s3.len_sq})) begin
			part_d = vict_pkg::PART_END;
		end else begin
			part_d = vict_pkg::PART_MID;
		end
	end

	// endpoint distance test
	assign ep_dist = (part_d == vict_pkg::PART_END) ? geom_s3.end_sq : geom_s3.st_sq;
	assign ep_lhs  = vict_pkg::EP_W'(ep_dist) << vict_pkg::SH_K;
	assign ep_in_d = ep_lhs <= vict_pkg::EP_W'(dsq);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 4: partial products of the cross magnitudes and of len * dsq
	always_ff @(posedge clk) begin
		part_s4  <= part_d;
		ep_in_s4 <= ep_in_d;
		for (int i = 0; i < 3; i++) begin
			hh_s4[i]  <= geom_s3.cmag[i][vict_pkg::MAG_W-1:vict_pkg::LO_W]
				* geom_s3.cmag[i][vict_pkg::MAG_W-1:vict_pkg::LO_W];
			hl_s4[i]  <= geom_s3.cmag[i][vict_pkg::MAG_W-1:vict_pkg::LO_W]
				* geom_s3.cmag[i][vict_pkg::LO_W-1:0];
			lo2_s4[i] <= geom_s3.cmag[i][vict_pkg::LO_W-1:0]
				* geom_s3.cmag[i][vict_pkg::LO_W-1:0];
		end
		pa_s4 <= geom_s3.len_sq[vict_pkg::SUM_W-1:vict_pkg::LL_W] * dsq;
		pb_s4 <= geom_s3.len_sq[vict_pkg::LL_W-1:0] * dsq;
	end

	// stage 5: recombine the partial products
	always_ff @(posedge clk) begin
		part_s5  <= part_s4;
		ep_in_s5 <= ep_in_s4;
		for (int i = 0; i < 3; i++) begin
			csq_s5[i] <= (vict_pkg::CSQ_W'(hh_s4[i]) << (2 * vict_pkg::LO_W))
				+ (vict_pkg::CSQ_W'(hl_s4[i]) << (vict_pkg::LO_W + 1))
				+ vict_pkg::CSQ_W'(lo2_s4[i]);
		end
		d2l_s5 <= (vict_pkg::D2L_W'(pa_s4) << vict_pkg::LL_W) + vict_pkg::D2L_W'(pb_s4);
	end

	// stage 6: squared length of the cross product
	always_ff @(posedge clk) begin
		part_s6  <= part_s5;
		ep_in_s6 <= ep_in_s5;
		d2l_s6   <= d2l_s5;
		csum_s6  <= vict_pkg::CS_W'(csq_s5[0]) + vict_pkg::CS_W'(csq_s5[1])
			+ vict_pkg::CS_W'(csq_s5[2]);
	end

	// stage 7: interior compare |AP x AB|^2 * 2^k <= D^2 * L, result register
	assign mid_lhs = vict_pkg::CMP_W'(csum_s6) << vict_pkg::SH_K;

	always_ff @(posedge clk) begin
		part_s7   <= part_s6;
		inside_s7 <= (part_s6 == vict_pkg::PART_MID)
			? (mid_lhs <= vict_pkg::CMP_W'(d2l_s6)) : ep_in_s6;
	end

	assign done         = valid_s7;
	assign inside_res   = inside_s7;
	assign nearest_part = part_s7;

	// a zero-length segment has no cross product and no length term
	a_degen_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && part_s5 == vict_pkg::PART_DEGEN)
			|-> (csq_s5[0] == '0 && csq_s5[1] == '0 && csq_s5[2] == '0))
		else $error("cross product nonzero on a degenerate segment");

	a_degen_no_d2l: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && part_s5 == vict_pkg::PART_DEGEN) |-> d2l_s5 == '0)
		else $error("length product nonzero on a degenerate segment");

	a_back_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 |-> $past(valid_s4, 3))
		else $error("result without a matching stage 4 item");

endmodule

`default_nettype wire

// ----- hw/rtl/voxel_in_capsule_test_unit.sv -----
// voxel_in_capsule_test_unit: top level of the voxel-in-capsule test.
// Depends on vict_pkg, vict_cfg, vict_front and vict_back.
//
// Usage:
//  - Program start_x/y/z, end_x/y/z and diameter over the APB port
//    (registers at byte addresses 0x00 to 0x18, 4 bytes apart) while no
//    voxel is in flight. pready is always high.
//  - Present a voxel on point_x/y/z with start high; busy is never raised,
//    so a transfer happens at every clock edge where start is high.
//  - Each voxel gives one result on inside_res and nearest_part, marked by
//    done for exactly one cycle once it has passed pipeline stages 1 to 7.
//    The receiver cannot stall the results.
//  - Throughput is one voxel per cycle: a seven-stage pipeline with valid
//    bits; the 17x17 product stage and the split squaring of the cross
//    product set its depth.
//  - Reset clears the pipeline valid bits, the coordinates to zero and the
//    diameter to 16 (one voxel with four fraction bits).
`default_nettype none

module voxel_in_capsule_test_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [vict_pkg::ADDR_W-1:0]            paddr,
	input  wire logic [vict_pkg::DATA_W-1:0]            pwdata,
	output logic      [vict_pkg::DATA_W-1:0]            prdata,
	output logic                                        pready,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_y,
	input  wire logic signed [vict_pkg::COORD_BITS-1:0] point_z,
	output logic                                        done,
	output logic                                        inside_res,
	output logic [1:0]                                  nearest_part
);

	vict_pkg::cfg_t  cfg;
	vict_pkg::geom_t geom_s3;
	logic            valid_s3;
	logic            in_valid;

	// the pipeline takes a voxel every cycle
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	vict_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vict_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.geom_s3  (geom_s3)
	);

	vict_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.geom_s3      (geom_s3),
		.dsq          (cfg.dsq),
		.done         (done),
		.inside_res   (inside_res),
		.nearest_part (nearest_part)
	);

	// every result traces back to an earlier voxel transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result strobe without a voxel transfer seven cycles before");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for voxel_in_capsule_test_unit, directed and random voxel tests.
// Needs vict_pkg and the unit's RTL; verdicts are predicted with exact wide integer math.

module tb;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int SCALE_K      = 2 * vict_pkg::DIAM_FRAC_BITS + 2;
	localparam int RAND_SETS    = 9;
	localparam int SET_VOXELS   = 50;

	typedef logic signed [vict_pkg::COORD_BITS-1:0] coord_t;
	typedef logic [vict_pkg::DIAM_W-1:0] diam_t;
	typedef struct packed {
		logic       in_capsule;
		logic [1:0] part;
	} verdict_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [vict_pkg::ADDR_W-1:0] paddr;
	logic [vict_pkg::DATA_W-1:0] pwdata;
	logic [vict_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        start;
	logic                        busy;
	coord_t                      point_x;
	coord_t                      point_y;
	coord_t                      point_z;
	logic                        done;
	logic                        inside_res;
	logic [1:0]                  nearest_part;

	// bench copy of the capsule registers
	coord_t seg_start [3];
	coord_t seg_end [3];
	diam_t  seg_diam;

	verdict_t pending_verdicts [$];
	int idle_pct = 8;
	int err_count = 0;
	int stall_cycles = 0;

	voxel_in_capsule_test_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.done         (done),
		.inside_res   (inside_res),
		.nearest_part (nearest_part)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// inside test and nearest part for one voxel against the current capsule
	function automatic verdict_t capsule_verdict(coord_t px, coord_t py, coord_t pz);
		coord_t       pt [3];
		longint       ab, ap, bp, len_sq, st_sq, far_sq, dot;
		logic [127:0] w_len, w_st, w_far, w_dot, dsq, lhs, rhs;
		verdict_t     v;
		int           i;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		len_sq = 0;
		st_sq = 0;
		far_sq = 0;
		dot = 0;
		for (i = 0; i < 3; i++) begin
			ab = longint'(seg_end[i]) - longint'(seg_start[i]);
			ap = longint'(pt[i]) - longint'(seg_start[i]);
			bp = longint'(pt[i]) - longint'(seg_end[i]);
			len_sq += ab * ab;
			st_sq += ap * ap;
			far_sq += bp * bp;
			dot += ab * ap;
		end
		w_len = len_sq;
		w_st = st_sq;
		w_far = far_sq;
		dsq = 128'(seg_diam) * 128'(seg_diam);
		if (len_sq == 0) begin
			v.part = vict_pkg::PART_DEGEN;
			v.in_capsule = (w_st << SCALE_K) <= dsq;
		end else if (dot <= 0) begin
			v.part = vict_pkg::PART_START;
			v.in_capsule = (w_st << SCALE_K) <= dsq;
		end else if (dot >= len_sq) begin
			v.part = vict_pkg::PART_END;
			v.in_capsule = (w_far << SCALE_K) <= dsq;
		end else begin
			// cross-multiplied: S - t^2/L <= r^2
			w_dot = dot;
			lhs = (w_st * w_len) << SCALE_K;
			rhs = ((w_dot * w_dot) << SCALE_K) + dsq * w_len;
			v.part = vict_pkg::PART_MID;
			v.in_capsule = lhs <= rhs;
		end
		return v;
	endfunction

	// point on the segment line at frac/1024 of its length, jittered by up to reach
	function automatic coord_t near_coord(coord_t s, coord_t e, int frac, int reach);
		longint base;
		base = longint'(s) + (longint'(e) - longint'(s)) * frac / 1024
			+ (int'($urandom_range(0, 2 * reach)) - reach);
		return coord_t'(base);
	endfunction

	// one APB write: setup then access, bench copy updated on the transfer
	task automatic write_reg(logic [vict_pkg::REG_IDX_W-1:0] idx,
		logic [vict_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			vict_pkg::REG_START_X: seg_start[0] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_START_Y: seg_start[1] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_START_Z: seg_start[2] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_END_X:   seg_end[0] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_END_Y:   seg_end[1] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_END_Z:   seg_end[2] = value[vict_pkg::COORD_BITS-1:0];
			vict_pkg::REG_DIAM:    seg_diam = value[vict_pkg::DIAM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// program the whole capsule, upper data bits filled with junk
	task automatic set_capsule(int sx, int sy, int sz, int ex, int ey, int ez, int d);
		logic [vict_pkg::DATA_W-1:0] junk;
		junk = $urandom();
		write_reg(vict_pkg::REG_START_X,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(sx)});
		junk = $urandom();
		write_reg(vict_pkg::REG_START_Y,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(sy)});
		junk = $urandom();
		write_reg(vict_pkg::REG_START_Z,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(sz)});
		junk = $urandom();
		write_reg(vict_pkg::REG_END_X,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(ex)});
		junk = $urandom();
		write_reg(vict_pkg::REG_END_Y,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(ey)});
		junk = $urandom();
		write_reg(vict_pkg::REG_END_Z,
			{junk[vict_pkg::DATA_W-1:vict_pkg::COORD_BITS], coord_t'(ez)});
		junk = $urandom();
		write_reg(vict_pkg::REG_DIAM,
			{junk[vict_pkg::DATA_W-1:vict_pkg::DIAM_W], diam_t'(d)});
	endtask

	// one voxel transfer after an optional random gap
	task automatic send_voxel(coord_t px, coord_t py, coord_t pz);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do @(posedge clk); while (busy);
		pending_verdicts.insert(pending_verdicts.size(), capsule_verdict(px, py, pz));
	endtask

	// stop sending and wait for every outstanding verdict
	task automatic drain_results();
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// degenerate capsule at the origin with the reset diameter
	task automatic test_reset_defaults();
		send_voxel(0, 0, 0);
		send_voxel(1, 0, 0);
		send_voxel(-32768, -32768, -32768);
		send_voxel(32767, 32767, 32767);
		drain_results();
	endtask

	// interior, both clamped ends, exact boundary and projection on the ends
	task automatic test_clamping();
		set_capsule(0, 0, 0, 10, 0, 0, 32);
		send_voxel(5, 1, 0);
		send_voxel(5, 2, 0);
		send_voxel(5, 0, 0);
		send_voxel(0, 1, 0);
		send_voxel(-1, 0, 0);
		send_voxel(10, 1, 0);
		send_voxel(11, 0, 0);
		send_voxel(10, 0, 0);
		drain_results();
		set_capsule(-3, 4, -5, 7, -6, 9, 100);
		send_voxel(2, -1, 2);
		send_voxel(-3, 4, -5);
		send_voxel(20, 20, 20);
		drain_results();
	endtask

	// zero radius: only points on the segment are inside
	task automatic test_zero_diameter();
		set_capsule(0, 0, 0, 10, 0, 0, 0);
		send_voxel(3, 0, 0);
		send_voxel(3, 1, 0);
		send_voxel(0, 0, 0);
		send_voxel(10, 0, 0);
		drain_results();
	endtask

	// full-range diagonal with the widest diameter
	task automatic test_extreme_span();
		set_capsule(-32768, -32768, -32768, 32767, 32767, 32767, 4095);
		send_voxel(-32768, 32767, -32768);
		send_voxel(32767, -32768, 32767);
		send_voxel(0, 0, 0);
		send_voxel(32767, 32767, 32767);
		send_voxel(-32768, -32768, -32768);
		drain_results();
	endtask

	// random capsules, mostly voxels near the segment, some uniform noise
	task automatic test_random_capsules();
		int     n, k, i, d, frac, reach;
		int     s [3];
		int     e [3];
		coord_t pt [3];
		for (n = 0; n < RAND_SETS; n++) begin
			idle_pct = (n < 3) ? 8 : (n < 6) ? 86 : 0;
			d = $urandom_range(1, 4095);
			for (i = 0; i < 3; i++) begin
				s[i] = int'(coord_t'($urandom()));
				e[i] = s[i] + int'($urandom_range(0, 600)) - 300;
			end
			case (n)
				0: begin
					for (i = 0; i < 3; i++) begin
						s[i] = -32768;
						e[i] = 32767;
					end
					d = 4095;
				end
				3: begin
					for (i = 0; i < 3; i++) begin
						s[i] = 32767;
						e[i] = -32768;
					end
					d = 1;
				end
				6: for (i = 0; i < 3; i++) e[i] = s[i];
				8: for (i = 0; i < 3; i++) e[i] = int'(coord_t'($urandom()));
				default: ;
			endcase
			set_capsule(s[0], s[1], s[2], e[0], e[1], e[2], d);
			reach = d / 32 + 3;
			for (k = 0; k < SET_VOXELS; k++) begin
				if ($urandom_range(99) < 75) begin
					frac = int'($urandom_range(0, 1408)) - 192;
					for (i = 0; i < 3; i++)
						pt[i] = near_coord(seg_start[i], seg_end[i], frac, reach);
				end else begin
					for (i = 0; i < 3; i++)
						pt[i] = coord_t'($urandom());
				end
				send_voxel(pt[0], pt[1], pt[2]);
			end
			drain_results();
		end
	endtask

	// compare each result transfer with the oldest predicted verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				err_count++;
				$display("%0t: result with none expected, inside_res=%b nearest_part=%0d",
					$time, inside_res, nearest_part);
			end else begin
				want = pending_verdicts.pop_front();
				if (inside_res !== want.in_capsule || nearest_part !== want.part) begin
					err_count++;
					$display("%0t: mismatch inside_res exp %b act %b, nearest_part exp %0d act %0d",
						$time, want.in_capsule, inside_res, want.part, nearest_part);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || (psel && penable))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		for (int i = 0; i < 3; i++) begin
			seg_start[i] = '0;
			seg_end[i] = '0;
		end
		seg_diam = vict_pkg::DIAM_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_clamping();
		test_zero_diameter();
		test_extreme_span();
		test_random_capsules();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
